[src/slipd_pkg.sv]
// Package for the SLIP frame decoder: framing bytes, phase codes, result kinds
// and the result record passed from the decoder core to the top level.
// No dependencies.
package slipd_pkg;

    // Framing bytes of the line code.
    localparam logic [7:0] CODE_END     = 8'hC0;
    localparam logic [7:0] CODE_ESC     = 8'hDB;
    localparam logic [7:0] CODE_ESC_END = 8'hDC;
    localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

    // Receive phase codes.
    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_FRAME = 2'd1;
    localparam logic [1:0] PHASE_ESC   = 2'd2;

    // Input mode codes.
    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_REARM = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Capacity after reset, in bytes.
    localparam logic [15:0] CAPACITY_RESET = 16'd4096;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
    } t_result;

endpackage

[src/slipd_core.sv]
// Decoder core of the SLIP frame decoder: frame phase, armed flag and length
// counter, with the result of the current item formed combinationally.
// Depends on slipd_pkg.
module slipd_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_mode,
    input  logic [7:0]             i_rx_byte,
    input  logic [15:0]            i_capacity,
    output slipd_pkg::t_result     o_result
);
    import slipd_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic        r_armed, n_armed;
    logic [15:0] r_len,   n_len;

    logic        store_req;
    logic [7:0]  store_val;
    logic        fail_req;
    t_result     res;

    always_comb begin
        n_phase   = r_phase;
        n_armed   = r_armed;
        n_len     = r_len;
        store_req = 1'b0;
        store_val = i_rx_byte;
        fail_req  = 1'b0;
        res       = '{kind: KIND_NONE, data_byte: 8'd0, byte_index: 16'd0,
                      frame_length: 16'd0};

        if (i_mode == MODE_REARM) begin
            n_armed = 1'b1;
        end else begin
            case (r_phase)
                PHASE_FRAME: begin
                    if (i_rx_byte == CODE_END) begin
                        // An empty frame closes silently and stays armed.
                        if (r_len != 16'd0) begin
                            res.kind         = KIND_DONE;
                            res.frame_length = r_len;
                            n_armed          = 1'b0;
                        end
                        n_len   = 16'd0;
                        n_phase = PHASE_IDLE;
                    end else if (i_rx_byte == CODE_ESC) begin
                        n_phase = PHASE_ESC;
                    end else begin
                        store_req = 1'b1;
                    end
                end
                PHASE_ESC: begin
                    n_phase = PHASE_FRAME;
                    if (i_rx_byte == CODE_ESC_END) begin
                        store_req = 1'b1;
                        store_val = CODE_END;
                    end else if (i_rx_byte == CODE_ESC_ESC) begin
                        store_req = 1'b1;
                        store_val = CODE_ESC;
                    end else begin
                        fail_req = 1'b1;
                    end
                end
                default: begin
                    n_phase = PHASE_IDLE;
                    if (i_rx_byte == CODE_END && r_armed) begin
                        n_len   = 16'd0;
                        n_phase = PHASE_FRAME;
                    end
                end
            endcase

            if (store_req) begin
                if (r_len < i_capacity) begin
                    res.kind       = KIND_DATA;
                    res.data_byte  = store_val;
                    res.byte_index = r_len;
                    n_len          = r_len + 16'd1;
                end else begin
                    fail_req = 1'b1;
                end
            end

            // The length is kept after an error until the next frame opens.
            if (fail_req) begin
                res.kind = KIND_ERR;
                n_armed  = 1'b0;
                n_phase  = PHASE_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_IDLE;
            r_armed <= 1'b0;
            r_len   <= 16'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_armed <= n_armed;
            r_len   <= n_len;
        end
    end

    assign o_result = res;

endmodule

[src/slip_frame_decoder_top.sv]
// Top level of the SLIP frame decoder: stream ports, capacity register and
// result register around the decoder core.
// Depends on slipd_pkg and slipd_core.
//
//  Channel   Direction  Handshake              Payload
//  s_axis    in         tvalid / tready        tdata[7:0] rx_byte, tuser[0] mode
//  m_axis    out        tvalid / tready        tdata: data_byte, byte_index,
//                                              frame_length; tuser[1:0] result_kind
//  cfg       in         valid / ready          data[15:0] rx_capacity
//
// Every accepted item yields exactly one result item, which appears in the cycle after
// it is accepted and is held in the result register until the downstream side takes it.
// A new item is accepted in every cycle in which the result register is empty
// or is being emptied in that same cycle, so the sustained rate is one item
// per clock; the only limit is the single result register.
// The capacity register is always ready; it is to be written only while idle (not enforced by the block).
// Reset is synchronous and active low: it returns the decoder to no frame,
// not armed, length zero, the capacity to 4096 and empties the result register.
module slip_frame_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input items.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  i_s_axis_tuser,   // [0] mode

    // Result items.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] data_byte, [23:8] byte_index, [39:24] frame_length
    output logic [39:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,   // [1:0] result_kind

    // Capacity register write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import slipd_pkg::*;

    logic [15:0] r_capacity;
    logic        r_out_valid;
    t_result     r_out;
    t_result     core_result;
    logic        in_accept;

    // The input side is free whenever the result register will be empty at
    // the next edge.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_data;
        end
    end

    slipd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_mode     (i_s_axis_tuser[0]),
        .i_rx_byte  (i_s_axis_tdata),
        .i_capacity (r_capacity),
        .o_result   (core_result)
    );

    // Result register: loaded on every accepted item, cleared when taken
    // without a new item behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {r_out.frame_length, r_out.byte_index, r_out.data_byte};

endmodule

[src/slipd_chk.sv]
// Port-level checker for the SLIP frame decoder, bound to the top level.
// Depends on slipd_pkg and slip_frame_decoder_top.
module slipd_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [39:0] o_m_axis_tdata,
    input  logic [1:0]  o_m_axis_tuser
);
    import slipd_pkg::*;

    // A result held back by the downstream side stays unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Results without payload carry all-zero data.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_NONE || o_m_axis_tuser == KIND_ERR)
            |-> o_m_axis_tdata == 40'd0)
        else $error("payload on a result without data");

    // A data byte carries no frame length.
    a_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_DATA |-> o_m_axis_tdata[39:24] == 16'd0)
        else $error("frame length on a data result");

    // A completed frame is never empty and carries only its length.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_DONE |->
            o_m_axis_tdata[23:0] == 24'd0 && o_m_axis_tdata[39:24] != 16'd0)
        else $error("malformed frame complete result");

endmodule

bind slip_frame_decoder_top slipd_chk u_slipd_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

[sim/tb.sv]
// Self-checking testbench for slip_frame_decoder_top: directed framing and capacity
// cases followed by random SLIP traffic, with each result checked against a
// behavioural decoder model. Depends on slipd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb;
    import slipd_pkg::*;

    localparam int TIMEOUT_NS = 5_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_valid;
    logic [7:0]  s_data;
    logic [0:0]  s_user;
    logic        m_ready = 1'b0;
    logic        cfg_valid;
    logic [15:0] cfg_data;
    logic        s_ready;
    logic        m_valid;
    logic [39:0] m_data;
    logic [1:0]  m_user;
    logic        cfg_ready;

    // Idle percentages of the sender and the receiver in the current phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int mismatch_count = 0;

    // Decoder model state and capacity register copy.
    logic [1:0]  phase_q;
    logic        armed_q;
    logic [15:0] len_q;
    logic [15:0] cap_q;

    t_result pending_decodes[$];

    slip_frame_decoder_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // A frame error drops the frame and gives up the receive buffer.
    function automatic t_result raise_frame_error();
        t_result r;
        r = '0;
        r.kind = KIND_ERR;
        armed_q = 1'b0;
        phase_q = PHASE_IDLE;
        return r;
    endfunction

    function automatic t_result store_decoded(input logic [7:0] b);
        t_result r;
        r = '0;
        if (len_q < cap_q) begin
            r.kind       = KIND_DATA;
            r.data_byte  = b;
            r.byte_index = len_q;
            len_q        = len_q + 16'd1;
        end else begin
            r = raise_frame_error();
        end
        return r;
    endfunction

    function automatic t_result decode_step(input logic mode, input logic [7:0] b);
        t_result r;
        r = '0;
        if (mode == MODE_REARM) begin
            armed_q = 1'b1;
            return r;
        end
        case (phase_q)
            PHASE_FRAME: begin
                if (b == CODE_END) begin
                    // An empty frame closes silently and keeps the buffer armed.
                    if (len_q != 16'd0) begin
                        r.kind         = KIND_DONE;
                        r.frame_length = len_q;
                        armed_q        = 1'b0;
                    end
                    len_q   = 16'd0;
                    phase_q = PHASE_IDLE;
                end else if (b == CODE_ESC) begin
                    phase_q = PHASE_ESC;
                end else begin
                    r = store_decoded(b);
                end
            end
            PHASE_ESC: begin
                phase_q = PHASE_FRAME;
                if (b == CODE_ESC_END)
                    r = store_decoded(CODE_END);
                else if (b == CODE_ESC_ESC)
                    r = store_decoded(CODE_ESC);
                else
                    r = raise_frame_error();
            end
            default: begin
                phase_q = PHASE_IDLE;
                if (b == CODE_END && armed_q) begin
                    len_q   = 16'd0;
                    phase_q = PHASE_FRAME;
                end
            end
        endcase
        return r;
    endfunction

    // Monitor: predicts on every accepted item and checks every accepted result.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            phase_q = PHASE_IDLE;
            armed_q = 1'b0;
            len_q   = 16'd0;
            cap_q   = CAPACITY_RESET;
            pending_decodes.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                cap_q = cfg_data;
            if (s_valid && s_ready)
                pending_decodes.push_back(decode_step(s_user[0], s_data));
            if (m_valid && m_ready) begin
                if (pending_decodes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: kind %0d tdata %h", m_user, m_data);
                end else begin
                    want = pending_decodes.pop_front();
                    if (m_user !== want.kind || m_data[7:0] !== want.data_byte
                            || m_data[23:8] !== want.byte_index
                            || m_data[39:24] !== want.frame_length) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: expected kind %0d byte %h idx %0d len %0d",
                                     want.kind, want.data_byte, want.byte_index,
                                     want.frame_length);
                            $display("          got kind %0d byte %h idx %0d len %0d",
                                     m_user, m_data[7:0], m_data[23:8], m_data[39:24]);
                        end
                    end
                end
            end
        end
    end

    always @(negedge i_clk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_item(input logic mode, input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid   <= 1'b1;
        s_user[0] <= mode;
        s_data    <= b;
        do @(posedge i_clk); while (!s_ready);
        items_sent++;
    endtask

    // Hold the sender off until every outstanding result has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_framing_rules();
        // Bytes while idle and not armed are ignored, END included.
        send_item(MODE_BYTE, CODE_END);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_REARM, 8'hFF);
        send_item(MODE_BYTE, 8'h55);
        // An empty frame leaves the buffer armed.
        send_item(MODE_BYTE, CODE_END);
        send_item(MODE_BYTE, CODE_END);
        send_item(MODE_BYTE, CODE_END);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_BYTE, CODE_ESC);
        send_item(MODE_BYTE, CODE_ESC_END);
        send_item(MODE_BYTE, CODE_ESC);
        send_item(MODE_BYTE, CODE_ESC_ESC);
        // Rearming inside a frame does not disturb it.
        send_item(MODE_REARM, 8'h00);
        send_item(MODE_BYTE, 8'h7E);
        send_item(MODE_BYTE, CODE_END);
        send_item(MODE_BYTE, CODE_END);
        // END straight after ESC is a bad escape, and so is any other byte.
        send_item(MODE_REARM, 8'hA5);
        send_item(MODE_BYTE, CODE_END);
        send_item(MODE_BYTE, CODE_ESC);
        send_item(MODE_BYTE, CODE_END);
        send_item(MODE_REARM, 8'h5A);
        send_item(MODE_BYTE, CODE_END);
        send_item(MODE_BYTE, CODE_ESC);
        send_item(MODE_BYTE, 8'h12);
    endtask

    task automatic test_capacity_limits();
        // With no capacity at all the first data byte is already an error.
        write_capacity(16'd0);
        send_item(MODE_REARM, 8'h00);
        send_item(MODE_BYTE, CODE_END);
        send_item(MODE_BYTE, 8'h41);
        write_capacity(16'd1);
        send_item(MODE_REARM, 8'h00);
        send_item(MODE_BYTE, CODE_END);
        send_item(MODE_BYTE, 8'h01);
        send_item(MODE_BYTE, 8'h02);
        // Escaped bytes count against the capacity as well.
        write_capacity(16'd2);
        send_item(MODE_REARM, 8'h00);
        send_item(MODE_BYTE, CODE_END);
        send_item(MODE_BYTE, CODE_ESC);
        send_item(MODE_BYTE, CODE_ESC_END);
        send_item(MODE_BYTE, CODE_ESC);
        send_item(MODE_BYTE, CODE_ESC_ESC);
        send_item(MODE_BYTE, CODE_ESC);
        send_item(MODE_BYTE, CODE_ESC_END);
        write_capacity(16'hFFFF);
        send_item(MODE_REARM, 8'h00);
        send_item(MODE_BYTE, CODE_END);
        send_item(MODE_BYTE, 8'hAA);
        send_item(MODE_BYTE, CODE_END);
    endtask

    // One frame with random content, sometimes preceded by line noise and
    // sometimes broken off or left unarmed.
    task automatic send_random_frame();
        int n;
        int r;
        logic [7:0] b;
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 4))
                send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
        if ($urandom_range(9) != 0)
            send_item(MODE_REARM, 8'($urandom_range(255)));
        send_item(MODE_BYTE, CODE_END);
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 20);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                send_item(MODE_BYTE, CODE_ESC);
                send_item(MODE_BYTE, CODE_ESC_END);
            end else if (r < 16) begin
                send_item(MODE_BYTE, CODE_ESC);
                send_item(MODE_BYTE, CODE_ESC_ESC);
            end else if (r < 18) begin
                send_item(MODE_BYTE, CODE_ESC);
                send_item(MODE_BYTE, 8'($urandom_range(255)));
            end else if (r < 20) begin
                send_item(MODE_REARM, 8'($urandom_range(255)));
            end else begin
                b = 8'($urandom_range(255));
                if (b == CODE_END || b == CODE_ESC)
                    b = b ^ 8'h01;
                send_item(MODE_BYTE, b);
            end
        end
        if ($urandom_range(19) != 0)
            send_item(MODE_BYTE, CODE_END);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [15:0] cap_a, input logic [15:0] cap_b,
                                       input int n_items);
        int goal;
        int next_pause;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_capacity(cap_a);
        goal       = items_sent + n_items;
        next_pause = items_sent + 150;
        while (items_sent < goal) begin
            send_random_frame();
            if (items_sent >= next_pause) begin
                drain_results();
                next_pause = items_sent + 150;
            end
            if (items_sent >= goal - n_items / 2 && cap_q != cap_b && cap_a != cap_b)
                write_capacity(cap_b);
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        s_valid   = 1'b0;
        s_data    = 8'h00;
        s_user    = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 16'h0000;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 54;
        test_framing_rules();
        test_capacity_limits();
        test_random_traffic(30, 54, 16'd7, 16'hFFFF, 560);
        test_random_traffic(54, 30, 16'($urandom_range(1, 24)), 16'd0, 560);
        test_random_traffic(0, 0, 16'd16, CAPACITY_RESET, 560);

        drain_results();
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0 && pending_decodes.size() == 0) begin
            $display("PASS slip_frame_decoder_top");
        end else begin
            $display("FAIL slip_frame_decoder_top");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL slip_frame_decoder_top");
        $finish;
    end

endmodule
